>>> src/tcs_pkg.sv
// Shared types and constants of the timed cue scheduler.
// Used by the controller, the datapath and the top level; no dependencies.
package tcs_pkg;

  localparam int MAX_CUES    = 16;
  localparam int TIME_W      = 31;
  localparam int ITEM_W      = 16;
  localparam int CUE_IDX_W   = 5;
  localparam int PTR_W       = $clog2(MAX_CUES + 1);
  localparam int ADDR_W      = (MAX_CUES > 1) ? $clog2(MAX_CUES) : 1;
  localparam int CUE_W       = 2 * TIME_W + ITEM_W;
  localparam int EVENT_LIMIT = 32;
  localparam int EV_CNT_W    = $clog2(EVENT_LIMIT + 1);

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_CLEAR = 2'd1,
    OP_SEEK  = 2'd2,
    OP_PLAY  = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    EV_RESET  = 3'd0,
    EV_BEGIN  = 3'd1,
    EV_END    = 3'd2,
    EV_DONE   = 3'd3,
    EV_REJECT = 3'd4
  } ev_kind_t;

  typedef enum logic [1:0] {
    SEL_BEG = 2'd0,
    SEL_END = 2'd1,
    SEL_IDX = 2'd2
  } addr_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_REJECT,
    ST_CLEAR,
    ST_SEEK_RST,
    ST_B_RD,
    ST_B_CMP,
    ST_E_RD,
    ST_E_CMP,
    ST_I_RD,
    ST_I_EMIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic      cap;
    logic      wr_cue;
    logic      clr_all;
    logic      clr_ptrs;
    addr_sel_t addr_sel;
    logic      inc_beg;
    logic      inc_end;
    logic      inc_idx;
    logic      inc_ev;
    logic      ld_idx;
    logic      push;
    ev_kind_t  kind;
    logic      with_cue;
    logic      last;
  } cmd_t;

  typedef struct packed {
    opcode_t opcode;
    logic    full;
    logic    beg_avail;
    logic    end_avail;
    logic    idx_avail;
    logic    ev_ok;
    logic    start_le;
    logic    stop_le;
    logic    push_ok;
  } stat_t;

endpackage

>>> src/timed_cue_scheduler_top.sv
// Timed cue scheduler: one input word per command, a burst of result words,
// the last one a done word with tlast set; a new command is taken only once
// the done word of the last one has been pushed. Play and seek walk the cue
// table one entry at a time (RAM address, then registered read and time
// compare), and any step that pushes a result waits while out_tready is low
// and a word is pending. The cue table RAM is not cleared; clear only resets
// the fill count and the begin and end pointers.
// Depends on tcs_pkg, tcs_ctrl, tcs_dp and tcs_ram.
module timed_cue_scheduler_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // [30:0] time_ms, [61:31] cue_start_ms, [92:62] cue_stop_ms, [108:93] cue_item
  input  logic [111:0] in_tdata,
  // [1:0] opcode
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // [4:0] cue_index, [20:5] event_item
  output logic [23:0]  out_tdata,
  // [2:0] event_kind
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  tcs_pkg::cmd_t  cmd;
  tcs_pkg::stat_t stat;
  logic [tcs_pkg::CUE_IDX_W-1:0] out_index;
  logic [tcs_pkg::ITEM_W-1:0]    out_item;

  tcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_opcode(in_tuser),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcs_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .in_opcode(in_tuser),
    .in_time  (in_tdata[30:0]),
    .in_start (in_tdata[61:31]),
    .in_stop  (in_tdata[92:62]),
    .in_item  (in_tdata[108:93]),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_kind (out_tuser),
    .out_index(out_index),
    .out_item (out_item),
    .out_last (out_tlast)
  );

  assign out_tdata = {3'b000, out_item, out_index};

endmodule

>>> src/tcs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module tcs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

>>> src/tcs_dp.sv
// Datapath of the timed cue scheduler: cue table RAM, pointers, time compare
// and the result register. Depends on tcs_pkg and tcs_ram.
module tcs_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  tcs_pkg::cmd_t                   cmd,
  output tcs_pkg::stat_t                  stat,
  input  logic [1:0]                      in_opcode,
  input  logic [tcs_pkg::TIME_W-1:0]      in_time,
  input  logic [tcs_pkg::TIME_W-1:0]      in_start,
  input  logic [tcs_pkg::TIME_W-1:0]      in_stop,
  input  logic [tcs_pkg::ITEM_W-1:0]      in_item,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_kind,
  output logic [tcs_pkg::CUE_IDX_W-1:0]   out_index,
  output logic [tcs_pkg::ITEM_W-1:0]      out_item,
  output logic                            out_last
);

  localparam int TW = tcs_pkg::TIME_W;
  localparam int IW = tcs_pkg::ITEM_W;

  tcs_pkg::opcode_t          opcode_r;
  logic [TW-1:0]             time_r, start_r, stop_r;
  logic [IW-1:0]             item_r;
  logic [tcs_pkg::PTR_W-1:0] count_r, beg_r, end_r, idx_r;
  logic [tcs_pkg::EV_CNT_W-1:0] events_r;
  logic [tcs_pkg::PTR_W-1:0] sel_ptr;
  logic [tcs_pkg::CUE_W-1:0] rd_data;
  logic [TW-1:0]             rd_start, rd_stop;
  logic [IW-1:0]             rd_item;

  logic                        out_valid_r;
  logic [2:0]                  out_kind_r;
  logic [tcs_pkg::CUE_IDX_W-1:0] out_index_r;
  logic [IW-1:0]               out_item_r;
  logic                        out_last_r;

  // Latch the input word.
  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      opcode_r <= tcs_pkg::opcode_t'(in_opcode);
      time_r   <= in_time;
      start_r  <= in_start;
      stop_r   <= in_stop;
      item_r   <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      beg_r    <= '0;
      end_r    <= '0;
      idx_r    <= '0;
      events_r <= '0;
    end else begin
      if (cmd.clr_all) begin
        count_r <= '0;
      end else if (cmd.wr_cue) begin
        count_r <= count_r + 1'b1;
      end
      if (cmd.clr_all || cmd.clr_ptrs) begin
        beg_r <= '0;
        end_r <= '0;
      end else begin
        if (cmd.inc_beg) beg_r <= beg_r + 1'b1;
        if (cmd.inc_end) end_r <= end_r + 1'b1;
      end
      if (cmd.ld_idx) begin
        idx_r <= end_r;
      end else if (cmd.inc_idx) begin
        idx_r <= idx_r + 1'b1;
      end
      if (cmd.cap) begin
        events_r <= '0;
      end else if (cmd.inc_ev) begin
        events_r <= events_r + 1'b1;
      end
    end
  end

  always_comb begin
    unique case (cmd.addr_sel)
      tcs_pkg::SEL_BEG: sel_ptr = beg_r;
      tcs_pkg::SEL_END: sel_ptr = end_r;
      tcs_pkg::SEL_IDX: sel_ptr = idx_r;
      default:          sel_ptr = beg_r;
    endcase
  end

  tcs_ram #(
    .WIDTH(tcs_pkg::CUE_W),
    .DEPTH(tcs_pkg::MAX_CUES)
  ) u_cue_ram (
    .clk    (clk),
    .wr_en  (cmd.wr_cue),
    .wr_addr(count_r[tcs_pkg::ADDR_W-1:0]),
    .wr_data({item_r, stop_r, start_r}),
    .rd_addr(sel_ptr[tcs_pkg::ADDR_W-1:0]),
    .rd_data(rd_data)
  );

  assign rd_start = rd_data[TW-1:0];
  assign rd_stop  = rd_data[2*TW-1:TW];
  assign rd_item  = rd_data[2*TW+IW-1:2*TW];

  assign stat.opcode    = opcode_r;
  assign stat.full      = (count_r == tcs_pkg::PTR_W'(tcs_pkg::MAX_CUES));
  assign stat.beg_avail = (beg_r < count_r);
  assign stat.end_avail = (end_r < count_r);
  assign stat.idx_avail = (idx_r < beg_r);
  assign stat.ev_ok     = (events_r < tcs_pkg::EV_CNT_W'(tcs_pkg::EVENT_LIMIT));
  assign stat.start_le  = (rd_start <= time_r);
  assign stat.stop_le   = (rd_stop <= time_r);
  assign stat.push_ok   = !out_valid_r || out_ready;

  // Result register: load on push, drop once taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_kind_r  <= cmd.kind;
      out_last_r  <= cmd.last;
      out_index_r <= cmd.with_cue ? tcs_pkg::CUE_IDX_W'(sel_ptr) : '0;
      out_item_r  <= cmd.with_cue ? rd_item : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_index = out_index_r;
  assign out_item  = out_item_r;
  assign out_last  = out_last_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= tcs_pkg::PTR_W'(tcs_pkg::MAX_CUES))
    else $error("cue count above table size");

  a_ptrs_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    beg_r <= count_r && end_r <= count_r)
    else $error("pointer beyond loaded cues");

  a_last_is_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_kind_r == tcs_pkg::EV_DONE)
    else $error("last set on a result other than done");

  a_push_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !out_valid_r || out_ready)
    else $error("result pushed over a pending word");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_cue |-> !stat.full)
    else $error("cue written into full table");

endmodule

>>> src/tcs_ctrl.sv
// Controller of the timed cue scheduler: sequences load, clear, seek and play
// over the datapath. Depends on tcs_pkg.
module tcs_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic [1:0]     in_opcode,
  output logic           in_ready,
  input  tcs_pkg::stat_t stat,
  output tcs_pkg::cmd_t  cmd
);

  tcs_pkg::state_t state_r, state_nxt;
  logic            seek;

  assign seek = (stat.opcode == tcs_pkg::OP_SEEK);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      tcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.cap = 1'b1;
          unique case (tcs_pkg::opcode_t'(in_opcode))
            tcs_pkg::OP_LOAD:  state_nxt = tcs_pkg::ST_LOAD;
            tcs_pkg::OP_CLEAR: state_nxt = tcs_pkg::ST_CLEAR;
            tcs_pkg::OP_SEEK:  state_nxt = tcs_pkg::ST_SEEK_RST;
            tcs_pkg::OP_PLAY:  state_nxt = tcs_pkg::ST_B_RD;
            default:           state_nxt = tcs_pkg::ST_DONE;
          endcase
        end
      end
      tcs_pkg::ST_LOAD: begin
        if (stat.full) begin
          state_nxt = tcs_pkg::ST_REJECT;
        end else begin
          cmd.wr_cue = 1'b1;
          state_nxt  = tcs_pkg::ST_DONE;
        end
      end
      tcs_pkg::ST_REJECT: begin
        if (stat.push_ok) begin
          cmd.push  = 1'b1;
          cmd.kind  = tcs_pkg::EV_REJECT;
          state_nxt = tcs_pkg::ST_DONE;
        end
      end
      tcs_pkg::ST_CLEAR: begin
        cmd.clr_all = 1'b1;
        state_nxt   = tcs_pkg::ST_DONE;
      end
      tcs_pkg::ST_SEEK_RST: begin
        if (stat.push_ok) begin
          cmd.push     = 1'b1;
          cmd.kind     = tcs_pkg::EV_RESET;
          cmd.clr_ptrs = 1'b1;
          state_nxt    = tcs_pkg::ST_B_RD;
        end
      end
      tcs_pkg::ST_B_RD: begin
        cmd.addr_sel = tcs_pkg::SEL_BEG;
        if (stat.beg_avail && (seek || stat.ev_ok)) begin
          state_nxt = tcs_pkg::ST_B_CMP;
        end else begin
          state_nxt = tcs_pkg::ST_E_RD;
        end
      end
      tcs_pkg::ST_B_CMP: begin
        cmd.addr_sel = tcs_pkg::SEL_BEG;
        if (!stat.start_le) begin
          state_nxt = tcs_pkg::ST_E_RD;
        end else if (seek) begin
          cmd.inc_beg = 1'b1;
          state_nxt   = tcs_pkg::ST_B_RD;
        end else if (stat.push_ok) begin
          cmd.push     = 1'b1;
          cmd.kind     = tcs_pkg::EV_BEGIN;
          cmd.with_cue = 1'b1;
          cmd.inc_beg  = 1'b1;
          cmd.inc_ev   = 1'b1;
          state_nxt    = tcs_pkg::ST_B_RD;
        end
      end
      tcs_pkg::ST_E_RD: begin
        cmd.addr_sel = tcs_pkg::SEL_END;
        if (stat.end_avail && (seek || stat.ev_ok)) begin
          state_nxt = tcs_pkg::ST_E_CMP;
        end else if (seek) begin
          cmd.ld_idx = 1'b1;
          state_nxt  = tcs_pkg::ST_I_RD;
        end else begin
          state_nxt = tcs_pkg::ST_DONE;
        end
      end
      tcs_pkg::ST_E_CMP: begin
        cmd.addr_sel = tcs_pkg::SEL_END;
        if (!stat.stop_le) begin
          if (seek) begin
            cmd.ld_idx = 1'b1;
            state_nxt  = tcs_pkg::ST_I_RD;
          end else begin
            state_nxt = tcs_pkg::ST_DONE;
          end
        end else if (seek) begin
          cmd.inc_end = 1'b1;
          state_nxt   = tcs_pkg::ST_E_RD;
        end else if (stat.push_ok) begin
          cmd.push     = 1'b1;
          cmd.kind     = tcs_pkg::EV_END;
          cmd.with_cue = 1'b1;
          cmd.inc_end  = 1'b1;
          cmd.inc_ev   = 1'b1;
          state_nxt    = tcs_pkg::ST_E_RD;
        end
      end
      tcs_pkg::ST_I_RD: begin
        cmd.addr_sel = tcs_pkg::SEL_IDX;
        if (stat.idx_avail) begin
          state_nxt = tcs_pkg::ST_I_EMIT;
        end else begin
          state_nxt = tcs_pkg::ST_DONE;
        end
      end
      tcs_pkg::ST_I_EMIT: begin
        cmd.addr_sel = tcs_pkg::SEL_IDX;
        if (stat.push_ok) begin
          cmd.push     = 1'b1;
          cmd.kind     = tcs_pkg::EV_BEGIN;
          cmd.with_cue = 1'b1;
          cmd.inc_idx  = 1'b1;
          state_nxt    = tcs_pkg::ST_I_RD;
        end
      end
      tcs_pkg::ST_DONE: begin
        if (stat.push_ok) begin
          cmd.push  = 1'b1;
          cmd.kind  = tcs_pkg::EV_DONE;
          cmd.last  = 1'b1;
          state_nxt = tcs_pkg::ST_IDLE;
        end
      end
      default: state_nxt = tcs_pkg::ST_IDLE;
    endcase
  end

endmodule
